/* sv/ep0_pkg.sv */
// ----------------------------------------------------------------------------
// ep0_pkg
// Shared types and codes for the control endpoint zero request responder.
// ----------------------------------------------------------------------------
package ep0_pkg;

  // result actions
  typedef enum logic [1:0] {
    ACT_STALL  = 2'd0,
    ACT_ACK    = 2'd1,
    ACT_INLINE = 2'd2,
    ACT_DESC   = 2'd3
  } action_t;

  // descriptor kinds as reported on the result
  typedef enum logic [1:0] {
    KIND_DEVICE = 2'd0,
    KIND_CONFIG = 2'd1,
    KIND_STRING = 2'd2
  } kind_t;

  // standard request codes
  localparam logic [7:0] REQ_GET_STATUS = 8'd0;
  localparam logic [7:0] REQ_SET_ADDRESS = 8'd5;
  localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
  localparam logic [7:0] REQ_GET_CONFIGURATION = 8'd8;
  localparam logic [7:0] REQ_SET_CONFIGURATION = 8'd9;

  // request type fields
  localparam logic [7:0] RT_TYPE_MASK = 8'h60;
  localparam logic [7:0] RT_STATUS_DEVICE = 8'h80;
  localparam logic [7:0] RT_STATUS_INTERFACE = 8'h81;
  localparam logic [7:0] RT_STATUS_ENDPOINT = 8'h82;
  localparam logic [7:0] EP_IN3_ADDR = 8'h83;

  // descriptor types in the high value byte
  localparam logic [7:0] DESC_TYPE_DEVICE = 8'd1;
  localparam logic [7:0] DESC_TYPE_CONFIG = 8'd2;
  localparam logic [7:0] DESC_TYPE_STRING = 8'd3;

  // configuration register indexes
  localparam int CFG_INDEX_W = 3;
  localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_LEN = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_CONFIG_LEN = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_STRING0_LEN = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_STRING1_LEN = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_STRING2_LEN = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_STRING3_LEN = 3'd5;

  localparam logic [7:0] DEVICE_LEN_RESET = 8'd18;
  localparam logic [7:0] CONFIG_LEN_RESET = 8'd9;
  localparam int STRING_REGS = 4;

  // chunk sequencing
  localparam logic [1:0] LAST_CHUNK_IDX = 2'd3;

  // one decoded request waiting for the back end
  typedef struct packed {
    action_t     action;
    logic [6:0]  byte_count;
    logic [7:0]  inline_byte0;
    kind_t       kind;
    logic [1:0]  string_select;
    logic        notify;
    logic [7:0]  remaining;
  } job_t;

  // one result word
  typedef struct packed {
    action_t     action;
    logic [6:0]  byte_count;
    logic [7:0]  inline_byte0;
    logic [7:0]  inline_byte1;
    kind_t       kind;
    logic [1:0]  string_select;
    logic [7:0]  chunk_offset;
    logic        ack_status;
    logic        host_mode_notify;
    logic        last;
  } result_t;

endpackage

/* sv/usb_ep0_standard_request_responder.sv */
// ----------------------------------------------------------------------------
// usb_ep0_standard_request_responder
// Answers standard requests on control endpoint zero, one setup word in,
// one to four result words out.
// ----------------------------------------------------------------------------
// Usage:
//   in_*   : one setup packet per word, valid/ready.
//   out_*  : result words, valid/ready; out_last marks the final word of a
//            request. Descriptor replies come as chunks naming kind, offset
//            and byte count; the data itself is fetched elsewhere.
//   cfg_*  : register writes (descriptor lengths), always ready; write only
//            while no request is in flight.
// Path: a setup word passes the job queue, the job register and the output
//   register. A request then gives one word per cycle, up to four, unless
//   out_ready is low. Throughput is set by the chunk sequencer emitting a
//   single word per cycle while out_ready is high; a two-entry job queue lets
//   the front keep taking setup words while the sequencer works.
// Reset: lengths return to 18 / 9 / 0, current configuration to zero,
//   queue and output register empty.
// Stall: out_ready low holds the output word; the sequencer and then the
//   queue fill up, and in_ready drops once the queue is full.
// ----------------------------------------------------------------------------
module usb_ep0_standard_request_responder #(
  parameter int PACKET_BYTES = 64,
  parameter int NUM_STRINGS  = 4
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [ep0_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                      cfg_data,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_request_type,
  input  logic [7:0]                      in_request_code,
  input  logic [7:0]                      in_value_low,
  input  logic [7:0]                      in_value_high,
  input  logic [7:0]                      in_index_low,
  input  logic [15:0]                     in_request_length,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [1:0]                      out_action,
  output logic [6:0]                      out_byte_count,
  output logic [7:0]                      out_inline_byte0,
  output logic [7:0]                      out_inline_byte1,
  output logic [1:0]                      out_descriptor_kind,
  output logic [1:0]                      out_string_select,
  output logic [7:0]                      out_chunk_offset,
  output logic                            out_ack_status,
  output logic                            out_host_mode_notify,
  output logic                            out_last
);
  import ep0_pkg::*;

  logic    q_full;
  logic    q_push;
  logic    q_pop;
  logic    q_not_empty;
  job_t    push_job;
  job_t    head_job;
  result_t out_word;

  assign cfg_ready = 1'b1;

  // front end
  ep0_decode #(
    .NUM_STRINGS(NUM_STRINGS)
  ) u_decode (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_valid        (cfg_valid),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_request_type  (in_request_type),
    .in_request_code  (in_request_code),
    .in_value_low     (in_value_low),
    .in_value_high    (in_value_high),
    .in_index_low     (in_index_low),
    .in_request_length(in_request_length),
    .q_full           (q_full),
    .q_push           (q_push),
    .q_job            (push_job)
  );

  // job queue
  ep0_job_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .not_empty(q_not_empty),
    .head_job (head_job)
  );

  // back end
  ep0_chunker #(
    .PACKET_BYTES(PACKET_BYTES)
  ) u_chunker (
    .clk        (clk),
    .rst_n      (rst_n),
    .q_not_empty(q_not_empty),
    .q_job      (head_job),
    .q_pop      (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_word   (out_word)
  );

  // result word fields
  assign out_action           = out_word.action;
  assign out_byte_count       = out_word.byte_count;
  assign out_inline_byte0     = out_word.inline_byte0;
  assign out_inline_byte1     = out_word.inline_byte1;
  assign out_descriptor_kind  = out_word.kind;
  assign out_string_select    = out_word.string_select;
  assign out_chunk_offset     = out_word.chunk_offset;
  assign out_ack_status       = out_word.ack_status;
  assign out_host_mode_notify = out_word.host_mode_notify;
  assign out_last             = out_word.last;

endmodule

/* sv/ep0_decode.sv */
// ----------------------------------------------------------------------------
// ep0_decode
// Front end: accepts setup words, holds the configuration registers and the
// current configuration, and turns each request into a job for the queue.
// ----------------------------------------------------------------------------
module ep0_decode #(
  parameter int NUM_STRINGS = 4
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       cfg_valid,
  input  logic [ep0_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [7:0]                 cfg_data,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [7:0]                 in_request_type,
  input  logic [7:0]                 in_request_code,
  input  logic [7:0]                 in_value_low,
  input  logic [7:0]                 in_value_high,
  input  logic [7:0]                 in_index_low,
  input  logic [15:0]                in_request_length,
  input  logic                       q_full,
  output logic                       q_push,
  output ep0_pkg::job_t              q_job
);
  import ep0_pkg::*;

  logic [7:0] dev_len_r;
  logic [7:0] cfg_len_r;
  logic [7:0] str_len_r [STRING_REGS];
  logic [7:0] cur_config_r;

  logic [7:0] desc_len;
  logic       desc_ok;
  job_t       job;

  assign in_ready = !q_full;
  assign q_push   = in_valid && !q_full;
  assign q_job    = job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dev_len_r <= DEVICE_LEN_RESET;
      cfg_len_r <= CONFIG_LEN_RESET;
      for (int i = 0; i < STRING_REGS; i++) str_len_r[i] <= 8'd0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_DEVICE_LEN:  dev_len_r    <= cfg_data;
        REG_CONFIG_LEN:  cfg_len_r    <= cfg_data;
        REG_STRING0_LEN: str_len_r[0] <= cfg_data;
        REG_STRING1_LEN: str_len_r[1] <= cfg_data;
        REG_STRING2_LEN: str_len_r[2] <= cfg_data;
        REG_STRING3_LEN: str_len_r[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  // current configuration, updated in request order
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_config_r <= 8'd0;
    end else if (q_push && (in_request_type & RT_TYPE_MASK) == 8'd0 &&
                 in_request_code == REQ_SET_CONFIGURATION) begin
      cur_config_r <= in_value_low;
    end
  end

  // descriptor length lookup
  always_comb begin
    desc_len = 8'd0;
    desc_ok  = 1'b1;
    case (in_value_high)
      DESC_TYPE_DEVICE: desc_len = dev_len_r;
      DESC_TYPE_CONFIG: desc_len = cfg_len_r;
      DESC_TYPE_STRING: begin
        desc_ok  = in_value_low < 8'(NUM_STRINGS);
        desc_len = str_len_r[in_value_low[1:0]];
      end
      default: desc_ok = 1'b0;
    endcase
  end

  // request classification
  always_comb begin
    job        = '0;
    job.action = ACT_STALL;
    if ((in_request_type & RT_TYPE_MASK) == 8'd0) begin
      case (in_request_code)
        REQ_GET_DESCRIPTOR: begin
          if (desc_ok) begin
            job.action    = ACT_DESC;
            job.remaining = (in_request_length < {8'h00, desc_len}) ?
                            in_request_length[7:0] : desc_len;
            case (in_value_high)
              DESC_TYPE_DEVICE: job.kind = KIND_DEVICE;
              DESC_TYPE_CONFIG: begin
                job.kind   = KIND_CONFIG;
                job.notify = 1'b1;
              end
              default: begin
                job.kind          = KIND_STRING;
                job.string_select = in_value_low[1:0];
              end
            endcase
          end
        end
        REQ_GET_STATUS: begin
          if (in_request_type == RT_STATUS_DEVICE) begin
            job.action       = ACT_INLINE;
            job.byte_count   = 7'd2;
            job.inline_byte0 = 8'd1;
          end else if (in_request_type == RT_STATUS_INTERFACE ||
                       (in_request_type == RT_STATUS_ENDPOINT &&
                        in_index_low == EP_IN3_ADDR)) begin
            job.action     = ACT_INLINE;
            job.byte_count = 7'd2;
          end
        end
        REQ_GET_CONFIGURATION: begin
          job.action       = ACT_INLINE;
          job.byte_count   = 7'd1;
          job.inline_byte0 = cur_config_r;
        end
        REQ_SET_CONFIGURATION, REQ_SET_ADDRESS: job.action = ACT_ACK;
        default: ;
      endcase
    end
  end

endmodule

/* sv/ep0_job_fifo.sv */
// ----------------------------------------------------------------------------
// ep0_job_fifo
// Two-entry queue of decoded jobs between the front and back ends.
// ----------------------------------------------------------------------------
module ep0_job_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  ep0_pkg::job_t  push_job,
  output logic           full,
  input  logic           pop,
  output logic           not_empty,
  output ep0_pkg::job_t  head_job
);
  import ep0_pkg::*;

  job_t       entry_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] count_r;

  assign full      = count_r == 2'd2;
  assign not_empty = count_r != 2'd0;
  assign head_job  = entry_r[rd_ptr_r];

  // entry storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_job;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      if (push) wr_ptr_r <= !wr_ptr_r;
      if (pop)  rd_ptr_r <= !rd_ptr_r;
      case ({push, pop})
        2'b10:   count_r <= count_r + 2'd1;
        2'b01:   count_r <= count_r - 2'd1;
        default: ;
      endcase
    end
  end

endmodule

/* sv/ep0_chunker.sv */
// ----------------------------------------------------------------------------
// ep0_chunker
// Back end: takes one job at a time and emits its result words, splitting a
// descriptor reply into packet-sized chunks, into an output register.
// ----------------------------------------------------------------------------
module ep0_chunker #(
  parameter int PACKET_BYTES = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_not_empty,
  input  ep0_pkg::job_t     q_job,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output ep0_pkg::result_t  out_word
);
  import ep0_pkg::*;

  localparam logic [7:0] PKT8 = 8'(PACKET_BYTES);
  localparam logic [6:0] PKT7 = 7'(PACKET_BYTES);

  job_t       job_r;
  logic       busy_r;
  logic [7:0] rem_r;
  logic [7:0] off_r;
  logic [1:0] n_r;
  logic       out_valid_r;
  result_t    out_r;

  logic       is_desc;
  logic       fits;
  logic [6:0] chunk;
  result_t    res;
  logic       emit;
  logic       done;

  // current result word
  always_comb begin
    is_desc = job_r.action == ACT_DESC;
    fits    = rem_r <= PKT8;
    chunk   = fits ? rem_r[6:0] : PKT7;
    res                  = '0;
    res.action           = job_r.action;
    res.inline_byte0     = job_r.inline_byte0;
    res.kind             = job_r.kind;
    res.string_select    = job_r.string_select;
    res.host_mode_notify = job_r.notify && n_r == 2'd0;
    if (is_desc) begin
      res.byte_count   = chunk;
      res.chunk_offset = off_r;
      res.ack_status   = rem_r < PKT8;
      res.last         = fits || n_r == LAST_CHUNK_IDX;
    end else begin
      res.byte_count = job_r.byte_count;
      res.ack_status = job_r.action != ACT_STALL;
      res.last       = 1'b1;
    end
  end

  assign emit      = busy_r && (!out_valid_r || out_ready);
  assign done      = emit && res.last;
  assign q_pop     = q_not_empty && (!busy_r || done);
  assign out_valid = out_valid_r;
  assign out_word  = out_r;

  // job sequencing
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (q_pop) begin
      busy_r <= 1'b1;
    end else if (done) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      job_r <= q_job;
      rem_r <= q_job.remaining;
      off_r <= 8'd0;
      n_r   <= 2'd0;
    end else if (emit) begin
      rem_r <= rem_r - {1'b0, chunk};
      off_r <= off_r + {1'b0, chunk};
      n_r   <= n_r + 2'd1;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) out_r <= res;
  end

endmodule

/* sv/ep0_checker.sv */
// ----------------------------------------------------------------------------
// ep0_checker
// Port-level checks on the result channel of the request responder.
// ----------------------------------------------------------------------------
module ep0_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [1:0] out_action,
  input logic [6:0] out_byte_count,
  input logic       out_ack_status,
  input logic       out_last
);
  import ep0_pkg::*;

  // a stalled word stays offered
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a stall is a single empty word
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_STALL |->
      out_last && out_byte_count == 7'd0 && !out_ack_status)
    else $error("malformed stall word");

  // only descriptor replies span several words
  a_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action != ACT_DESC |-> out_last)
    else $error("non-descriptor reply not marked last");

  // a short chunk that acknowledges status ends the reply
  a_ack_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_action == ACT_DESC && out_ack_status |-> out_last)
    else $error("status acknowledged before the final chunk");

endmodule

bind usb_ep0_standard_request_responder ep0_checker u_ep0_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_action    (out_action),
  .out_byte_count(out_byte_count),
  .out_ack_status(out_ack_status),
  .out_last      (out_last)
);

/* verif/tb_usb_ep0_standard_request_responder.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_usb_ep0_standard_request_responder
// Self-checking bench for the endpoint zero request responder. Setup words
// go in over valid/ready with random gaps. Descriptor lengths are reloaded
// between phases. A scoreboard class predicts every result word: stalls,
// status, acks and inline replies, and descriptor chunks. It then compares each
// word that comes out, field by field, in order.
// ----------------------------------------------------------------------------
module tb_usb_ep0_standard_request_responder;
  import ep0_pkg::*;

  localparam int PACKET_BYTES  = 64;
  localparam int STRINGS       = 4;
  localparam int MAX_CHUNKS    = LAST_CHUNK_IDX + 1;
  localparam int SETTLE_CYCLES = 8;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_PHASES = 6;
  localparam int PHASE_SETUPS  = 66;
  localparam logic [CFG_INDEX_W-1:0] LEN_REGS [6] = '{REG_DEVICE_LEN, REG_CONFIG_LEN,
    REG_STRING0_LEN, REG_STRING1_LEN, REG_STRING2_LEN, REG_STRING3_LEN};

  // one setup packet as seen on the input word
  typedef struct packed {
    logic [7:0]  request_type;
    logic [7:0]  request_code;
    logic [7:0]  value_low;
    logic [7:0]  value_high;
    logic [7:0]  index_low;
    logic [15:0] request_length;
  } setup_t;

  function automatic setup_t make_setup(logic [7:0] rt, logic [7:0] code, logic [7:0] vl,
                                        logic [7:0] vh, logic [7:0] il, logic [15:0] len);
    setup_t s;
    s.request_type   = rt;
    s.request_code   = code;
    s.value_low      = vl;
    s.value_high     = vh;
    s.index_low      = il;
    s.request_length = len;
    return s;
  endfunction

  // reply predictor and in-order checker
  class reply_board;
    result_t    expected_words[$];
    logic [7:0] desc_len [8];
    logic [7:0] active_cfg;
    int         errors;
    int         setups;
    int         words;
    int         stalls;
    int         chunks;

    function new();
      desc_len = '{default: 8'd0};
      desc_len[REG_DEVICE_LEN] = DEVICE_LEN_RESET;
      desc_len[REG_CONFIG_LEN] = CONFIG_LEN_RESET;
      active_cfg = 8'd0;
      errors = 0;
      setups = 0;
      words  = 0;
      stalls = 0;
      chunks = 0;
    endfunction

    task report(string what);
      $display("MISMATCH @%0t: %s", $time, what);
      errors++;
    endtask

    function void write_length(logic [CFG_INDEX_W-1:0] idx, logic [7:0] v);
      desc_len[idx] = v;
    endfunction

    function int pending();
      return expected_words.size();
    endfunction

    function result_t make_word(action_t act, int count, logic [7:0] b0, kind_t k,
                                logic [1:0] sel, int off, bit ack, bit notify, bit fin);
      result_t w;
      w = '0;
      w.action           = act;
      w.byte_count       = 7'(count);
      w.inline_byte0     = b0;
      w.inline_byte1     = 8'd0;
      w.kind             = k;
      w.string_select    = sel;
      w.chunk_offset     = 8'(off);
      w.ack_status       = ack;
      w.host_mode_notify = notify;
      w.last             = fin;
      return w;
    endfunction

    function void push_stall();
      expected_words.push_back(make_word(ACT_STALL, 0, 8'd0, KIND_DEVICE, 2'd0, 0, 0, 0, 1));
    endfunction

    // descriptor reply: clamp to requested length, cut into packets
    function void predict_descriptor(setup_t s);
      int         total;
      int         remaining;
      int         offset;
      int         n;
      int         count;
      kind_t      k;
      logic [1:0] sel;
      bit         notify;
      bit         ack;
      bit         fin;
      sel    = 2'd0;
      notify = 0;
      case (s.value_high)
        DESC_TYPE_DEVICE: begin
          k     = KIND_DEVICE;
          total = desc_len[REG_DEVICE_LEN];
        end
        DESC_TYPE_CONFIG: begin
          k      = KIND_CONFIG;
          total  = desc_len[REG_CONFIG_LEN];
          notify = 1;
        end
        DESC_TYPE_STRING: begin
          if (s.value_low >= STRINGS) begin
            push_stall();
            return;
          end
          k     = KIND_STRING;
          sel   = s.value_low[1:0];
          total = desc_len[REG_STRING0_LEN + sel];
        end
        default: begin
          push_stall();
          return;
        end
      endcase
      remaining = (s.request_length < total) ? s.request_length : total;
      offset    = 0;
      n         = 0;
      do begin
        count = (remaining <= PACKET_BYTES) ? remaining : PACKET_BYTES;
        ack   = remaining < PACKET_BYTES;
        fin   = (remaining == count) || (n == MAX_CHUNKS - 1);
        expected_words.push_back(make_word(ACT_DESC, count, 8'd0, k, sel, offset, ack,
                                           (n == 0) && notify, fin));
        remaining -= count;
        offset    += count;
        n++;
      end while (remaining > 0 && n < MAX_CHUNKS);
    endfunction

    // expected reply for one accepted setup word
    function void note_setup(setup_t s);
      setups++;
      if ((s.request_type & RT_TYPE_MASK) != 8'd0) begin
        push_stall();
        return;
      end
      case (s.request_code)
        REQ_GET_DESCRIPTOR: predict_descriptor(s);
        REQ_GET_STATUS: begin
          if (s.request_type == RT_STATUS_DEVICE)
            expected_words.push_back(make_word(ACT_INLINE, 2, 8'd1, KIND_DEVICE, 2'd0, 0,
                                               1, 0, 1));
          else if (s.request_type == RT_STATUS_INTERFACE ||
                   (s.request_type == RT_STATUS_ENDPOINT && s.index_low == EP_IN3_ADDR))
            expected_words.push_back(make_word(ACT_INLINE, 2, 8'd0, KIND_DEVICE, 2'd0, 0,
                                               1, 0, 1));
          else
            push_stall();
        end
        REQ_GET_CONFIGURATION: begin
          expected_words.push_back(make_word(ACT_INLINE, 1, active_cfg, KIND_DEVICE, 2'd0, 0,
                                             1, 0, 1));
        end
        REQ_SET_CONFIGURATION: begin
          active_cfg = s.value_low;
          expected_words.push_back(make_word(ACT_ACK, 0, 8'd0, KIND_DEVICE, 2'd0, 0, 1, 0, 1));
        end
        REQ_SET_ADDRESS: begin
          expected_words.push_back(make_word(ACT_ACK, 0, 8'd0, KIND_DEVICE, 2'd0, 0, 1, 0, 1));
        end
        default: push_stall();
      endcase
    endfunction

    task check_field(string name, logic [15:0] got, logic [15:0] want);
      if (got !== want)
        report($sformatf("word %0d: %s is %0h, expected %0h", words, name, got, want));
    endtask

    task check_word(result_t got);
      result_t want;
      words++;
      if (got.action == ACT_STALL) stalls++;
      if (got.action == ACT_DESC) chunks++;
      if (expected_words.size() == 0) begin
        report($sformatf("word %0d arrived with nothing expected (%h)", words, got));
        return;
      end
      want = expected_words.pop_front();
      check_field("action", got.action, want.action);
      check_field("byte_count", got.byte_count, want.byte_count);
      check_field("inline_byte0", got.inline_byte0, want.inline_byte0);
      check_field("inline_byte1", got.inline_byte1, want.inline_byte1);
      check_field("descriptor_kind", got.kind, want.kind);
      check_field("string_select", got.string_select, want.string_select);
      check_field("chunk_offset", got.chunk_offset, want.chunk_offset);
      check_field("ack_status", got.ack_status, want.ack_status);
      check_field("host_mode_notify", got.host_mode_notify, want.host_mode_notify);
      check_field("last", got.last, want.last);
    endtask
  endclass

  logic                   clk;
  logic                   rst_n;
  logic                   cfg_valid;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [7:0]             cfg_data;
  logic                   in_valid;
  logic                   in_ready;
  logic [7:0]             in_request_type;
  logic [7:0]             in_request_code;
  logic [7:0]             in_value_low;
  logic [7:0]             in_value_high;
  logic [7:0]             in_index_low;
  logic [15:0]            in_request_length;
  logic                   out_valid;
  logic                   out_ready;
  logic [1:0]             out_action;
  logic [6:0]             out_byte_count;
  logic [7:0]             out_inline_byte0;
  logic [7:0]             out_inline_byte1;
  logic [1:0]             out_descriptor_kind;
  logic [1:0]             out_string_select;
  logic [7:0]             out_chunk_offset;
  logic                   out_ack_status;
  logic                   out_host_mode_notify;
  logic                   out_last;

  reply_board board;
  logic [7:0] len_plan [6];
  bit         gaps_on;
  bit         stalls_on;
  int         cycles;
  int         settings_used;

  usb_ep0_standard_request_responder #(
    .PACKET_BYTES(PACKET_BYTES),
    .NUM_STRINGS (STRINGS)
  ) dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_request_type     (in_request_type),
    .in_request_code     (in_request_code),
    .in_value_low        (in_value_low),
    .in_value_high       (in_value_high),
    .in_index_low        (in_index_low),
    .in_request_length   (in_request_length),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_action          (out_action),
    .out_byte_count      (out_byte_count),
    .out_inline_byte0    (out_inline_byte0),
    .out_inline_byte1    (out_inline_byte1),
    .out_descriptor_kind (out_descriptor_kind),
    .out_string_select   (out_string_select),
    .out_chunk_offset    (out_chunk_offset),
    .out_ack_status      (out_ack_status),
    .out_host_mode_notify(out_host_mode_notify),
    .out_last            (out_last)
  );

  // clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // run limit
  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycles, board.pending());
      $display("Verification failed");
      $finish;
    end
  end

  // sample both handshakes at the rising edge
  always @(posedge clk) begin : watch_ports
    result_t seen;
    if (rst_n && in_valid && in_ready)
      board.note_setup(make_setup(in_request_type, in_request_code, in_value_low,
                                  in_value_high, in_index_low, in_request_length));
    if (rst_n && out_valid && out_ready) begin
      seen.action           = action_t'(out_action);
      seen.byte_count       = out_byte_count;
      seen.inline_byte0     = out_inline_byte0;
      seen.inline_byte1     = out_inline_byte1;
      seen.kind             = kind_t'(out_descriptor_kind);
      seen.string_select    = out_string_select;
      seen.chunk_offset     = out_chunk_offset;
      seen.ack_status       = out_ack_status;
      seen.host_mode_notify = out_host_mode_notify;
      seen.last             = out_last;
      board.check_word(seen);
    end
  end

  // result side back-pressure in random bursts
  initial begin
    out_ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (stalls_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(negedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // drive one setup word after an optional gap, return once it is taken
  task automatic push_setup(input setup_t s, input int gap);
    if (gap > 0) begin
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid          <= 1'b1;
    in_request_type   <= s.request_type;
    in_request_code   <= s.request_code;
    in_value_low      <= s.value_low;
    in_value_high     <= s.value_high;
    in_index_low      <= s.index_low;
    in_request_length <= s.request_length;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // stop sending and let every expected word come out
  task automatic drain_replies();
    @(negedge clk);
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write all six descriptor lengths from len_plan
  task automatic load_lengths();
    for (int i = 0; i < 6; i++) begin
      @(negedge clk);
      cfg_valid <= 1'b1;
      cfg_index <= LEN_REGS[i];
      cfg_data  <= len_plan[i];
      @(posedge clk);
      while (!cfg_ready) @(posedge clk);
      board.write_length(LEN_REGS[i], len_plan[i]);
    end
    @(negedge clk);
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  // mostly well-formed standard requests with random content, some noise
  function automatic setup_t random_setup();
    setup_t s;
    int     pick;
    s = make_setup(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                   16'($urandom));
    pick = $urandom_range(0, 99);
    if (pick < 10) return s;
    s.request_type = {s.request_type[7], 2'b00, s.request_type[4:0]};
    if (pick < 55) begin
      s.request_code = REQ_GET_DESCRIPTOR;
      if ($urandom_range(0, 9) != 0)
        s.value_high = 8'($urandom_range(DESC_TYPE_DEVICE, DESC_TYPE_STRING));
      if ($urandom_range(0, 9) != 0)
        s.value_low = 8'($urandom_range(0, STRINGS - 1));
      case ($urandom_range(0, 5))
        0:       s.request_length = 16'd0;
        1:       s.request_length = 16'($urandom_range(1, PACKET_BYTES - 1));
        2:       s.request_length = 16'(PACKET_BYTES * $urandom_range(1, 4));
        3:       s.request_length = 16'($urandom_range(0, 300));
        4:       s.request_length = 16'hFFFF;
        default: ;
      endcase
    end else if (pick < 70) begin
      s.request_code = REQ_GET_STATUS;
      case ($urandom_range(0, 3))
        0:       s.request_type = RT_STATUS_DEVICE;
        1:       s.request_type = RT_STATUS_INTERFACE;
        2:       s.request_type = RT_STATUS_ENDPOINT;
        default: ;
      endcase
      if ($urandom_range(0, 1) == 1) s.index_low = EP_IN3_ADDR;
    end else if (pick < 80) begin
      s.request_code = REQ_GET_CONFIGURATION;
    end else if (pick < 90) begin
      s.request_code = REQ_SET_CONFIGURATION;
    end else if (pick < 95) begin
      s.request_code = REQ_SET_ADDRESS;
    end
    return s;
  endfunction

  // stimulus
  initial begin
    int ph;
    int n;
    board             = new();
    cycles            = 0;
    settings_used     = 1;
    gaps_on           = 0;
    stalls_on         = 0;
    rst_n             = 1'b0;
    cfg_valid         = 1'b0;
    cfg_index         = REG_DEVICE_LEN;
    cfg_data          = 8'd0;
    in_valid          = 1'b0;
    in_request_type   = 8'd0;
    in_request_code   = 8'd0;
    in_value_low      = 8'd0;
    in_value_high     = 8'd0;
    in_index_low      = 8'd0;
    in_request_length = 16'd0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed, lengths at reset values
    push_setup(make_setup(8'h80, REQ_GET_DESCRIPTOR, 8'd0, DESC_TYPE_DEVICE, 8'd0, 16'hFFFF), 0);
    // direction bit is ignored
    push_setup(make_setup(8'h00, REQ_GET_DESCRIPTOR, 8'd0, DESC_TYPE_CONFIG, 8'd0, 16'hFFFF), 0);
    // empty string descriptor gives a zero-length chunk
    push_setup(make_setup(8'h80, REQ_GET_DESCRIPTOR, 8'd0, DESC_TYPE_STRING, 8'd0, 16'hFFFF), 0);
    push_setup(make_setup(RT_STATUS_DEVICE, REQ_GET_STATUS, 8'd0, 8'd0, 8'd0, 16'd2), 0);
    push_setup(make_setup(RT_STATUS_INTERFACE, REQ_GET_STATUS, 8'd0, 8'd0, 8'd0, 16'd2), 0);
    push_setup(make_setup(RT_STATUS_ENDPOINT, REQ_GET_STATUS, 8'd0, 8'd0, EP_IN3_ADDR, 16'd2), 0);
    push_setup(make_setup(RT_STATUS_ENDPOINT, REQ_GET_STATUS, 8'd0, 8'd0, 8'h03, 16'd2), 0);
    push_setup(make_setup(8'h00, REQ_GET_STATUS, 8'd0, 8'd0, 8'd0, 16'd2), 0);
    push_setup(make_setup(8'h80, REQ_GET_CONFIGURATION, 8'd0, 8'd0, 8'd0, 16'd1), 0);
    push_setup(make_setup(8'h00, REQ_SET_CONFIGURATION, 8'hFF, 8'd0, 8'd0, 16'd0), 0);
    push_setup(make_setup(8'h80, REQ_GET_CONFIGURATION, 8'd0, 8'd0, 8'd0, 16'd1), 0);
    push_setup(make_setup(8'h00, REQ_SET_ADDRESS, 8'h7F, 8'd0, 8'd0, 16'd0), 0);
    // class, vendor and reserved request types stall
    push_setup(make_setup(8'hA1, REQ_GET_DESCRIPTOR, 8'd0, DESC_TYPE_DEVICE, 8'd0, 16'd64), 0);
    push_setup(make_setup(8'hC0, REQ_GET_STATUS, 8'd0, 8'd0, 8'd0, 16'd2), 0);
    push_setup(make_setup(8'hE0, REQ_SET_ADDRESS, 8'd1, 8'd0, 8'd0, 16'd0), 0);
    push_setup(make_setup(8'h80, 8'hFF, 8'd0, 8'd0, 8'd0, 16'd0), 0);
    drain_replies();

    // directed, lengths chosen for multi-packet and boundary replies
    len_plan = '{8'd255, 8'd128, 8'd64, 8'd0, 8'd1, 8'd200};
    load_lengths();
    push_setup(make_setup(8'h80, REQ_GET_DESCRIPTOR, 8'd0, DESC_TYPE_DEVICE, 8'd0, 16'hFFFF), 0);
    push_setup(make_setup(8'h80, REQ_GET_DESCRIPTOR, 8'd0, DESC_TYPE_CONFIG, 8'd0, 16'hFFFF), 0);
    push_setup(make_setup(8'h80, REQ_GET_DESCRIPTOR, 8'd0, DESC_TYPE_STRING, 8'd0, 16'hFFFF), 0);
    push_setup(make_setup(8'h80, REQ_GET_DESCRIPTOR, 8'd1, DESC_TYPE_STRING, 8'd0, 16'hFFFF), 0);
    push_setup(make_setup(8'h80, REQ_GET_DESCRIPTOR, 8'd3, DESC_TYPE_STRING, 8'hFF, 16'd100), 0);
    push_setup(make_setup(8'h80, REQ_GET_DESCRIPTOR, 8'd0, DESC_TYPE_DEVICE, 8'd0, 16'd0), 0);
    push_setup(make_setup(8'h80, REQ_GET_DESCRIPTOR, 8'd0, DESC_TYPE_DEVICE, 8'd0, 16'd65), 0);
    // string index out of range and unknown descriptor types stall
    push_setup(make_setup(8'h80, REQ_GET_DESCRIPTOR, 8'd4, DESC_TYPE_STRING, 8'd0, 16'hFFFF), 0);
    push_setup(make_setup(8'h80, REQ_GET_DESCRIPTOR, 8'hFF, DESC_TYPE_STRING, 8'd0, 16'd8), 0);
    push_setup(make_setup(8'h80, REQ_GET_DESCRIPTOR, 8'd0, 8'd0, 8'd0, 16'hFFFF), 0);
    push_setup(make_setup(8'h80, REQ_GET_DESCRIPTOR, 8'd0, 8'hFF, 8'd0, 16'hFFFF), 0);
    drain_replies();

    // random phases, each with its own set of lengths
    for (ph = 0; ph < RANDOM_PHASES; ph++) begin
      case (ph)
        0:       len_plan = '{default: 8'd255};
        1:       len_plan = '{default: 8'd0};
        2:       len_plan = '{8'd192, 8'd64, 8'd128, 8'd0, 8'd255, 8'd63};
        default: foreach (len_plan[i]) len_plan[i] = 8'($urandom_range(0, 255));
      endcase
      load_lengths();
      // closing phase runs at full rate on both sides
      gaps_on   = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      stalls_on = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      for (n = 0; n < PHASE_SETUPS; n++) begin
        if (ph != RANDOM_PHASES - 1 && $urandom_range(0, 39) == 0) drain_replies();
        push_setup(random_setup(),
                   (gaps_on && $urandom_range(0, 3) == 0) ? $urandom_range(1, 14) : 0);
      end
      drain_replies();
    end

    $display("covered %0d setup words and %0d result words (%0d stalls, %0d chunks)",
             board.setups, board.words, board.stalls, board.chunks);
    $display("over %0d descriptor length settings, %0d mismatches", settings_used,
             board.errors);
    if (board.errors == 0)
      $display("Verification passed");
    else
      $display("Verification failed");
    $finish;
  end

endmodule

/* sim.f */
sv/ep0_pkg.sv
sv/ep0_decode.sv
sv/ep0_job_fifo.sv
sv/ep0_chunker.sv
sv/usb_ep0_standard_request_responder.sv
sv/ep0_checker.sv
verif/tb_usb_ep0_standard_request_responder.sv
